FILE: src/bes_pkg.sv
// ----------------------------------------------------------------------------
// Bloch Euler step package
// Shared types and constants for the controller and the datapath.
// ----------------------------------------------------------------------------
package bes_pkg;

    localparam int unsigned ACC_W       = 99;
    localparam int unsigned STEP_CYCLES = 21;
    localparam int unsigned CNT_W       = $clog2(STEP_CYCLES);
    localparam int unsigned CFG_IDX_W   = 2;

    localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(STEP_CYCLES - 1);

    localparam logic [CFG_IDX_W-1:0] CFG_LONG_RELAX  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_TRANS_RELAX = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_TIME_STEP   = 2'd2;

    localparam logic CMD_LOAD = 1'b0;
    localparam logic CMD_STEP = 1'b1;

    localparam logic signed [ACC_W-1:0] RND_BIAS = 99'sh800_0000_0000;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_RUN,
        ST_EMIT
    } t_state;

    typedef enum logic [2:0] {
        A_R1,
        A_R2,
        A_W1X,
        A_W1Y,
        A_DW0,
        A_SLO,
        A_SHI
    } t_asel;

    typedef enum logic [2:0] {
        B_X,
        B_Y,
        B_Z,
        B_EQ,
        B_DT
    } t_bsel;

    typedef enum logic [2:0] {
        ACC_NONE,
        ACC_SET_ADD,
        ACC_SET_SUB,
        ACC_ADD,
        ACC_SUB,
        ACC_SCL_LO,
        ACC_SCL_HI
    } t_acc_op;

    typedef enum logic [1:0] {
        WB_NONE,
        WB_X,
        WB_Y,
        WB_Z
    } t_wb;

    typedef struct packed {
        logic    load_en;
        logic    rate_en;
        t_asel   asel;
        t_bsel   bsel;
        t_acc_op acc_op;
        t_wb     wb;
        logic    out_cap;
    } t_cmd;

endpackage

FILE: src/bes_in_if.sv
// ----------------------------------------------------------------------------
// Bloch Euler step input channel
// Valid/ready channel carrying one load or step transaction.
// ----------------------------------------------------------------------------
interface bes_in_if;
    logic               valid;
    logic               ready;
    logic               command;
    logic signed [31:0] load_x;
    logic signed [31:0] load_y;
    logic signed [31:0] load_z;
    logic signed [31:0] load_eq;
    logic signed [31:0] rf_x;
    logic signed [31:0] rf_y;
    logic signed [31:0] off_resonance;
    logic               last;

    modport source (
        output valid, command, load_x, load_y, load_z, load_eq,
        output rf_x, rf_y, off_resonance, last,
        input  ready
    );

    modport sink (
        input  valid, command, load_x, load_y, load_z, load_eq,
        input  rf_x, rf_y, off_resonance, last,
        output ready
    );
endinterface

FILE: src/bes_out_if.sv
// ----------------------------------------------------------------------------
// Bloch Euler step output channel
// Valid/ready channel carrying the emitted magnetization vector.
// ----------------------------------------------------------------------------
interface bes_out_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] out_x;
    logic signed [31:0] out_y;
    logic signed [31:0] out_z;
    logic signed [31:0] out_eq;

    modport source (
        output valid, out_x, out_y, out_z, out_eq,
        input  ready
    );

    modport sink (
        input  valid, out_x, out_y, out_z, out_eq,
        output ready
    );
endinterface

FILE: src/bes_dpath.sv
// ----------------------------------------------------------------------------
// Bloch Euler step datapath
// Configuration and state registers, one shared multiplier, a wide
// accumulator, rounding, saturation and the output register.
// ----------------------------------------------------------------------------
module bes_dpath (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_cfg_we,
    input  logic [bes_pkg::CFG_IDX_W-1:0]    i_cfg_idx,
    input  logic [31:0]                      i_cfg_data,
    input  bes_pkg::t_cmd                    i_cmd,
    input  logic signed [31:0]               i_load_x,
    input  logic signed [31:0]               i_load_y,
    input  logic signed [31:0]               i_load_z,
    input  logic signed [31:0]               i_load_eq,
    input  logic signed [31:0]               i_rf_x,
    input  logic signed [31:0]               i_rf_y,
    input  logic signed [31:0]               i_off_res,
    output logic signed [31:0]               o_out_x,
    output logic signed [31:0]               o_out_y,
    output logic signed [31:0]               o_out_z,
    output logic signed [31:0]               o_out_eq
);
    import bes_pkg::*;

    logic [30:0]              r_r1;
    logic [30:0]              r_r2;
    logic [31:0]              r_dt;
    logic signed [31:0]       r_hx, r_hy, r_hz, r_heq;
    logic signed [31:0]       r_nx, r_ny;
    logic signed [31:0]       r_w1x, r_w1y, r_dw0;
    logic signed [66:0]       r_prod;
    t_acc_op                  r_pop;
    logic signed [ACC_W-1:0]  r_acc;
    logic signed [31:0]       r_ox, r_oy, r_oz, r_oeq;

    logic signed [33:0]       w_a;
    logic signed [32:0]       w_b;
    logic signed [66:0]       w_prod;
    logic signed [ACC_W-1:0]  w_ext;
    logic signed [ACC_W-1:0]  w_shl;
    logic signed [ACC_W-1:0]  n_acc;
    logic signed [31:0]       w_held;
    logic signed [54:0]       w_inc;
    logic signed [55:0]       w_sum;
    logic signed [31:0]       w_sat;

    always_comb begin
        case (i_cmd.asel)
            A_R1:    w_a = {3'b000, r_r1};
            A_R2:    w_a = {3'b000, r_r2};
            A_W1X:   w_a = {{2{r_w1x[31]}}, r_w1x};
            A_W1Y:   w_a = {{2{r_w1y[31]}}, r_w1y};
            A_DW0:   w_a = {{2{r_dw0[31]}}, r_dw0};
            A_SLO:   w_a = {1'b0, r_acc[32:0]};
            A_SHI:   w_a = {r_acc[65], r_acc[65:33]};
            default: w_a = '0;
        endcase
        case (i_cmd.bsel)
            B_X:     w_b = {r_hx[31], r_hx};
            B_Y:     w_b = {r_hy[31], r_hy};
            B_Z:     w_b = {r_hz[31], r_hz};
            B_EQ:    w_b = {r_heq[31], r_heq};
            B_DT:    w_b = {1'b0, r_dt};
            default: w_b = '0;
        endcase
    end

    assign w_prod = w_a * w_b;
    assign w_ext  = {{(ACC_W-67){r_prod[66]}}, r_prod};
    assign w_shl  = {w_ext[ACC_W-34:0], 33'b0};

    always_comb begin
        case (r_pop)
            ACC_SET_ADD: n_acc = w_ext;
            ACC_SET_SUB: n_acc = -w_ext;
            ACC_ADD:     n_acc = r_acc + w_ext;
            ACC_SUB:     n_acc = r_acc - w_ext;
            ACC_SCL_LO:  n_acc = RND_BIAS + w_ext;
            ACC_SCL_HI:  n_acc = r_acc + w_shl;
            default:     n_acc = r_acc;
        endcase
    end

    always_comb begin
        case (i_cmd.wb)
            WB_X:    w_held = r_hx;
            WB_Y:    w_held = r_hy;
            WB_Z:    w_held = r_hz;
            default: w_held = r_hz;
        endcase
        w_inc = r_acc[ACC_W-1:44];
        w_sum = {{24{w_held[31]}}, w_held} + {w_inc[54], w_inc};
        if (!w_sum[55] && (w_sum[54:31] != '0)) begin
            w_sat = 32'sh7fff_ffff;
        end else if (w_sum[55] && (w_sum[54:31] != '1)) begin
            w_sat = 32'sh8000_0000;
        end else begin
            w_sat = w_sum[31:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_r1  <= '0;
            r_r2  <= '0;
            r_dt  <= '0;
            r_hx  <= '0;
            r_hy  <= '0;
            r_hz  <= '0;
            r_heq <= '0;
            r_pop <= ACC_NONE;
        end else begin
            r_pop <= i_cmd.acc_op;
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_LONG_RELAX:  r_r1 <= i_cfg_data[30:0];
                    CFG_TRANS_RELAX: r_r2 <= i_cfg_data[30:0];
                    CFG_TIME_STEP:   r_dt <= i_cfg_data;
                    default: begin
                    end
                endcase
            end
            if (i_cmd.load_en) begin
                r_hx  <= i_load_x;
                r_hy  <= i_load_y;
                r_hz  <= i_load_z;
                r_heq <= i_load_eq;
            end else if (i_cmd.wb == WB_Z) begin
                r_hx <= r_nx;
                r_hy <= r_ny;
                r_hz <= w_sat;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_prod <= w_prod;
        r_acc  <= n_acc;
        if (i_cmd.rate_en) begin
            r_w1x <= i_rf_x;
            r_w1y <= i_rf_y;
            r_dw0 <= i_off_res;
        end
        if (i_cmd.wb == WB_X) begin
            r_nx <= w_sat;
        end
        if (i_cmd.wb == WB_Y) begin
            r_ny <= w_sat;
        end
        if (i_cmd.out_cap) begin
            r_ox  <= r_hx;
            r_oy  <= r_hy;
            r_oz  <= r_hz;
            r_oeq <= r_heq;
        end
    end

    assign o_out_x  = r_ox;
    assign o_out_y  = r_oy;
    assign o_out_z  = r_oz;
    assign o_out_eq = r_oeq;

endmodule

FILE: src/bes_ctrl.sv
// ----------------------------------------------------------------------------
// Bloch Euler step controller
// Handshake control and the micro-operation sequence of one Euler step.
// ----------------------------------------------------------------------------
module bes_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    input  logic          i_command,
    input  logic          i_last,
    output logic          o_in_ready,
    output logic          o_out_valid,
    input  logic          i_out_ready,
    output bes_pkg::t_cmd o_cmd
);
    import bes_pkg::*;

    t_state             r_state, n_state;
    logic [CNT_W-1:0]   r_cnt, n_cnt;
    logic               r_last, n_last;
    logic               r_out_vld, n_out_vld;
    logic               w_accept;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_IDLE;
            r_cnt     <= '0;
            r_last    <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_cnt     <= n_cnt;
            r_last    <= n_last;
            r_out_vld <= n_out_vld;
        end
    end

    assign o_in_ready  = (r_state == ST_IDLE);
    assign o_out_valid = r_out_vld;
    assign w_accept    = i_in_valid && o_in_ready;

    always_comb begin
        n_state   = r_state;
        n_cnt     = r_cnt;
        n_last    = r_last;
        n_out_vld = r_out_vld && !i_out_ready;
        o_cmd     = '{load_en: 1'b0, rate_en: 1'b0, asel: A_R1, bsel: B_X,
                      acc_op: ACC_NONE, wb: WB_NONE, out_cap: 1'b0};
        case (r_state)
            ST_IDLE: begin
                if (w_accept) begin
                    n_last = i_last;
                    n_cnt  = '0;
                    if (i_command == CMD_STEP) begin
                        o_cmd.rate_en = 1'b1;
                        n_state       = ST_RUN;
                    end else begin
                        o_cmd.load_en = 1'b1;
                        n_state       = i_last ? ST_EMIT : ST_IDLE;
                    end
                end
            end
            ST_RUN: begin
                case (r_cnt)
                    5'd0:  begin o_cmd.asel = A_R2;  o_cmd.bsel = B_X;
                                 o_cmd.acc_op = ACC_SET_SUB; end
                    5'd1:  begin o_cmd.asel = A_DW0; o_cmd.bsel = B_Y;
                                 o_cmd.acc_op = ACC_ADD; end
                    5'd2:  begin o_cmd.asel = A_W1Y; o_cmd.bsel = B_Z;
                                 o_cmd.acc_op = ACC_SUB; end
                    5'd4:  begin o_cmd.asel = A_SLO; o_cmd.bsel = B_DT;
                                 o_cmd.acc_op = ACC_SCL_LO; end
                    5'd5:  begin o_cmd.asel = A_SHI; o_cmd.bsel = B_DT;
                                 o_cmd.acc_op = ACC_SCL_HI; end
                    5'd6:  begin o_cmd.asel = A_DW0; o_cmd.bsel = B_X;
                                 o_cmd.acc_op = ACC_SET_SUB; end
                    5'd7:  begin o_cmd.asel = A_R2;  o_cmd.bsel = B_Y;
                                 o_cmd.acc_op = ACC_SUB; o_cmd.wb = WB_X; end
                    5'd8:  begin o_cmd.asel = A_W1X; o_cmd.bsel = B_Z;
                                 o_cmd.acc_op = ACC_ADD; end
                    5'd10: begin o_cmd.asel = A_SLO; o_cmd.bsel = B_DT;
                                 o_cmd.acc_op = ACC_SCL_LO; end
                    5'd11: begin o_cmd.asel = A_SHI; o_cmd.bsel = B_DT;
                                 o_cmd.acc_op = ACC_SCL_HI; end
                    5'd12: begin o_cmd.asel = A_W1Y; o_cmd.bsel = B_X;
                                 o_cmd.acc_op = ACC_SET_ADD; end
                    5'd13: begin o_cmd.asel = A_W1X; o_cmd.bsel = B_Y;
                                 o_cmd.acc_op = ACC_SUB; o_cmd.wb = WB_Y; end
                    5'd14: begin o_cmd.asel = A_R1;  o_cmd.bsel = B_Z;
                                 o_cmd.acc_op = ACC_SUB; end
                    5'd15: begin o_cmd.asel = A_R1;  o_cmd.bsel = B_EQ;
                                 o_cmd.acc_op = ACC_ADD; end
                    5'd17: begin o_cmd.asel = A_SLO; o_cmd.bsel = B_DT;
                                 o_cmd.acc_op = ACC_SCL_LO; end
                    5'd18: begin o_cmd.asel = A_SHI; o_cmd.bsel = B_DT;
                                 o_cmd.acc_op = ACC_SCL_HI; end
                    5'd20: begin o_cmd.wb = WB_Z; end
                    default: begin
                    end
                endcase
                if (r_cnt == CNT_LAST) begin
                    n_state = r_last ? ST_EMIT : ST_IDLE;
                end else begin
                    n_cnt = r_cnt + 1'b1;
                end
            end
            ST_EMIT: begin
                if (!r_out_vld || i_out_ready) begin
                    o_cmd.out_cap = 1'b1;
                    n_out_vld     = 1'b1;
                    n_state       = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

`ifndef ASSERT_OFF
    a_cnt_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_RUN) |-> (r_cnt <= CNT_LAST))
        else $error("step counter beyond the sequence");

    a_step_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && (i_command == CMD_STEP)) |=> (r_state == ST_RUN && r_cnt == '0))
        else $error("accepted step did not start the sequence");

    a_cap_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.out_cap |-> (!r_out_vld || i_out_ready))
        else $error("output register overwritten before it was taken");

    a_emit_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.out_cap |=> r_out_vld)
        else $error("captured result not presented");
`endif

endmodule

FILE: src/bloch_euler_step_core.sv
// ----------------------------------------------------------------------------
// Bloch Euler step core
// Load: writes the state registers; with last, the emit state then captures
// the vector and raises valid. Step: a micro-operation sequence on one shared
// 34x33 multiplier (ten products and two scaling passes per axis). Input is
// accepted only while idle. A waiting result stalls only the next emit.
// Synchronous active-low reset clears the state, rates and time step.
// ----------------------------------------------------------------------------
module bloch_euler_step_core (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic [bes_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [31:0]                   i_cfg_data,
    bes_in_if.sink                        i_in,
    bes_out_if.source                     o_out
);
    import bes_pkg::*;

    t_cmd w_cmd;

    bes_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in.valid),
        .i_command   (i_in.command),
        .i_last      (i_in.last),
        .o_in_ready  (i_in.ready),
        .o_out_valid (o_out.valid),
        .i_out_ready (o_out.ready),
        .o_cmd       (w_cmd)
    );

    bes_dpath u_dpath (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_cmd      (w_cmd),
        .i_load_x   (i_in.load_x),
        .i_load_y   (i_in.load_y),
        .i_load_z   (i_in.load_z),
        .i_load_eq  (i_in.load_eq),
        .i_rf_x     (i_in.rf_x),
        .i_rf_y     (i_in.rf_y),
        .i_off_res  (i_in.off_resonance),
        .o_out_x    (o_out.out_x),
        .o_out_y    (o_out.out_y),
        .o_out_z    (o_out.out_z),
        .o_out_eq   (o_out.out_eq)
    );

endmodule

FILE: dv/tb.sv
// ----------------------------------------------------------------------------
// Bloch Euler step core testbench
// Sends load and step transactions over the input channel with random
// gaps and back-pressure, and programs the relaxation rates and the time
// step between phases. A behavioural model of the fixed-point Euler update
// predicts every emitted vector, which is checked field by field in order.
// ----------------------------------------------------------------------------
module tb;
    import bes_pkg::*;

    localparam int unsigned WATCHDOG_LIMIT = 5000;
    localparam int unsigned SETTLE_CYCLES  = 2 * STEP_CYCLES + 8;
    localparam int unsigned HOLD_STRETCH   = 400;

    localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 2'd3;

    localparam logic signed [99:0] HALF_LSB = 100'sd1 <<< 43;
    localparam logic signed [99:0] MAG_MAX  = 100'sd2147483647;
    localparam logic signed [99:0] MAG_MIN  = -(100'sd2147483648);

    localparam logic signed [31:0] W_MAX = 32'sh7fff_ffff;
    localparam logic signed [31:0] W_MIN = 32'sh8000_0000;
    localparam logic signed [31:0] W_ONE = 32'sh4000_0000;

    typedef struct {
        logic               command;
        logic signed [31:0] load_x;
        logic signed [31:0] load_y;
        logic signed [31:0] load_z;
        logic signed [31:0] load_eq;
        logic signed [31:0] rf_x;
        logic signed [31:0] rf_y;
        logic signed [31:0] off_resonance;
        logic               last;
    } t_item;

    typedef struct {
        logic signed [31:0] x;
        logic signed [31:0] y;
        logic signed [31:0] z;
        logic signed [31:0] eq;
    } t_vec;

    logic              i_clk;
    logic              i_rst_n;
    logic              i_cfg_we;
    logic [CFG_IDX_W-1:0] i_cfg_idx;
    logic [31:0]       i_cfg_data;

    bes_in_if  in_ch ();
    bes_out_if out_ch ();

    bloch_euler_step_core DUT (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_in       (in_ch),
        .o_out      (out_ch)
    );

    logic signed [31:0] mag_x   = '0;
    logic signed [31:0] mag_y   = '0;
    logic signed [31:0] mag_z   = '0;
    logic signed [31:0] mag_eq  = '0;
    logic [30:0]        relax_long  = '0;
    logic [30:0]        relax_trans = '0;
    logic [31:0]        step_dt     = '0;

    t_vec expected_vectors[$];
    int   n_errors          = 0;
    int   sink_hold_cycles  = 0;
    bit   idling_on         = 1'b1;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    function automatic logic signed [31:0] euler_update(input logic signed [31:0] base,
                                                        input logic signed [65:0] rate_sum);
        logic signed [99:0] scaled;
        scaled = rate_sum * $signed({1'b0, step_dt});
        scaled = (scaled + HALF_LSB) >>> 44;
        scaled = scaled + base;
        if (scaled > MAG_MAX)
            return W_MAX;
        if (scaled < MAG_MIN)
            return W_MIN;
        return scaled[31:0];
    endfunction

    task automatic predict_transaction(input t_item it);
        logic signed [31:0] r1s;
        logic signed [31:0] r2s;
        logic signed [65:0] dx;
        logic signed [65:0] dy;
        logic signed [65:0] dz;
        if (it.command == CMD_LOAD) begin
            mag_x  = it.load_x;
            mag_y  = it.load_y;
            mag_z  = it.load_z;
            mag_eq = it.load_eq;
        end else begin
            r1s = {1'b0, relax_long};
            r2s = {1'b0, relax_trans};
            dx = -(r2s * mag_x) + it.off_resonance * mag_y - it.rf_y * mag_z;
            dy = -(it.off_resonance * mag_x) - r2s * mag_y + it.rf_x * mag_z;
            dz = it.rf_y * mag_x - it.rf_x * mag_y - r1s * mag_z + r1s * mag_eq;
            mag_x = euler_update(mag_x, dx);
            mag_y = euler_update(mag_y, dy);
            mag_z = euler_update(mag_z, dz);
        end
        if (it.last)
            expected_vectors.push_back('{mag_x, mag_y, mag_z, mag_eq});
    endtask

    always @(posedge i_clk) begin
        t_item seen;
        if (i_rst_n) begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_LONG_RELAX:  relax_long  = i_cfg_data[30:0];
                    CFG_TRANS_RELAX: relax_trans = i_cfg_data[30:0];
                    CFG_TIME_STEP:   step_dt     = i_cfg_data;
                    default: ;
                endcase
            end
            if (in_ch.valid && in_ch.ready) begin
                seen.command       = in_ch.command;
                seen.load_x        = in_ch.load_x;
                seen.load_y        = in_ch.load_y;
                seen.load_z        = in_ch.load_z;
                seen.load_eq       = in_ch.load_eq;
                seen.rf_x          = in_ch.rf_x;
                seen.rf_y          = in_ch.rf_y;
                seen.off_resonance = in_ch.off_resonance;
                seen.last          = in_ch.last;
                predict_transaction(seen);
            end
        end
    end

    task automatic check_field(input string name, input logic signed [31:0] want,
                               input logic signed [31:0] got);
        if (got !== want) begin
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
            n_errors++;
        end
    endtask

    always @(posedge i_clk) begin
        t_vec want;
        if (i_rst_n && out_ch.valid && out_ch.ready) begin
            if (expected_vectors.size() == 0) begin
                $display("%0t: unexpected result, expected none, actual %0d %0d %0d %0d",
                         $time, out_ch.out_x, out_ch.out_y, out_ch.out_z, out_ch.out_eq);
                n_errors++;
            end else begin
                want = expected_vectors.pop_front();
                check_field("out_x", want.x, out_ch.out_x);
                check_field("out_y", want.y, out_ch.out_y);
                check_field("out_z", want.z, out_ch.out_z);
                check_field("out_eq", want.eq, out_ch.out_eq);
            end
        end
    end

    initial begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < WATCHDOG_LIMIT) begin
            @(posedge i_clk);
            if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) || i_cfg_we)
                quiet = 0;
            else
                quiet++;
        end
        $display("%0t: no transaction for %0d cycles", $time, WATCHDOG_LIMIT);
        $display("Some tests failed");
        $finish;
    end

    initial begin : sink_driver
        int   gap;
        logic rdy;
        gap = 0;
        out_ch.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (sink_hold_cycles > 0) begin
                sink_hold_cycles--;
                rdy = 1'b0;
            end else begin
                if (gap == 0 && idling_on && $urandom_range(0, 5) == 0)
                    gap = $urandom_range(1, 19);
                if (gap > 0) begin
                    gap--;
                    rdy = 1'b0;
                end else begin
                    rdy = 1'b1;
                end
            end
            out_ch.ready <= rdy;
        end
    end

    task automatic drive_fields(input t_item it);
        in_ch.command       <= it.command;
        in_ch.load_x        <= it.load_x;
        in_ch.load_y        <= it.load_y;
        in_ch.load_z        <= it.load_z;
        in_ch.load_eq       <= it.load_eq;
        in_ch.rf_x          <= it.rf_x;
        in_ch.rf_y          <= it.rf_y;
        in_ch.off_resonance <= it.off_resonance;
        in_ch.last          <= it.last;
    endtask

    task automatic send_item(input t_item it);
        int gap;
        gap = 0;
        if (idling_on && $urandom_range(0, 3) == 0)
            gap = $urandom_range(1, 19);
        if (gap > 0) begin
            in_ch.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        drive_fields(it);
        in_ch.valid <= 1'b1;
        @(posedge i_clk);
        while (!in_ch.ready) @(posedge i_clk);
    endtask

    task automatic wait_quiet();
        in_ch.valid <= 1'b0;
        @(posedge i_clk);
        while (expected_vectors.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic program_rates(input logic [31:0] r1, input logic [31:0] r2,
                                 input logic [31:0] dt, input bit spare);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= CFG_LONG_RELAX;
        i_cfg_data <= r1;
        @(posedge i_clk);
        i_cfg_idx  <= CFG_TRANS_RELAX;
        i_cfg_data <= r2;
        @(posedge i_clk);
        i_cfg_idx  <= CFG_TIME_STEP;
        i_cfg_data <= dt;
        @(posedge i_clk);
        if (spare) begin
            i_cfg_idx  <= CFG_SPARE;
            i_cfg_data <= $urandom;
            @(posedge i_clk);
        end
        i_cfg_we <= 1'b0;
    endtask

    function automatic logic signed [31:0] rand_mag();
        case ($urandom_range(0, 2))
            0: return $urandom;
            1: return $urandom_range(0, 32'h7fff_ffff) - 32'h4000_0000;
            default: begin
                case ($urandom_range(0, 3))
                    0: return W_MIN;
                    1: return W_MAX;
                    2: return W_ONE;
                    default: return -W_ONE;
                endcase
            end
        endcase
    endfunction

    function automatic logic signed [31:0] rand_rate();
        case ($urandom_range(0, 4))
            0: return $urandom;
            1, 2: return $urandom_range(0, 32'h00ff_ffff) - 32'h0080_0000;
            3: return $urandom_range(0, 1) ? W_MAX : W_MIN;
            default: return '0;
        endcase
    endfunction

    function automatic t_item load_item(input logic signed [31:0] x, input logic signed [31:0] y,
                                        input logic signed [31:0] z, input logic signed [31:0] eq,
                                        input bit last);
        t_item it;
        it.command       = CMD_LOAD;
        it.load_x        = x;
        it.load_y        = y;
        it.load_z        = z;
        it.load_eq       = eq;
        it.rf_x          = $urandom;
        it.rf_y          = $urandom;
        it.off_resonance = $urandom;
        it.last          = last;
        return it;
    endfunction

    function automatic t_item step_item(input logic signed [31:0] w1x,
                                        input logic signed [31:0] w1y,
                                        input logic signed [31:0] dw0, input bit last);
        t_item it;
        it.command       = CMD_STEP;
        it.load_x        = $urandom;
        it.load_y        = $urandom;
        it.load_z        = $urandom;
        it.load_eq       = $urandom;
        it.rf_x          = w1x;
        it.rf_y          = w1y;
        it.off_resonance = dw0;
        it.last          = last;
        return it;
    endfunction

    task automatic program_setting(input int mode);
        case (mode)
            0: program_rates($urandom_range(0, 32'h0010_0000), $urandom_range(0, 32'h0040_0000),
                             $urandom_range(32'h0000_1000, 32'h0100_0000), 1'b0);
            1: program_rates($urandom, $urandom, $urandom, 1'b1);
            2: program_rates(32'h7fff_ffff, 32'h7fff_ffff, 32'hffff_ffff, 1'b0);
            3: program_rates(32'h0, 32'h0, $urandom_range(32'h0000_0100, 32'h0010_0000), 1'b0);
            default: program_rates($urandom_range(0, 32'h0004_0000),
                                   $urandom_range(0, 32'h0004_0000),
                                   $urandom_range(32'h0000_0001, 32'h0004_0000), 1'b1);
        endcase
    endtask

    task automatic run_sequences(input int n_items);
        int sent;
        int n_steps;
        sent = 0;
        while (sent < n_items) begin
            if ($urandom_range(0, 6) == 0) begin
                send_item(step_item($urandom, $urandom, $urandom, $urandom_range(0, 1)));
                if ($urandom_range(0, 1))
                    send_item(load_item($urandom, $urandom, $urandom, $urandom,
                                        $urandom_range(0, 1)));
                sent += 2;
            end else begin
                send_item(load_item(rand_mag(), rand_mag(), rand_mag(), rand_mag(),
                                    $urandom_range(0, 7) == 0));
                n_steps = $urandom_range(1, 8);
                for (int i = 0; i < n_steps; i++)
                    send_item(step_item(rand_rate(), rand_rate(), rand_rate(),
                                        i == n_steps - 1 || $urandom_range(0, 9) == 0));
                sent += n_steps + 1;
            end
        end
    endtask

    task automatic test_reset_values();
        send_item(step_item($urandom, $urandom, $urandom, 1'b1));
    endtask

    task automatic test_load_emit();
        send_item(load_item(W_MIN, W_MIN, W_MIN, W_MIN, 1'b1));
        send_item(load_item(W_MAX, W_MAX, W_MAX, W_MAX, 1'b1));
        send_item(load_item('0, '0, '0, '0, 1'b0));
        send_item(load_item($urandom, $urandom, $urandom, $urandom, 1'b1));
    endtask

    task automatic test_zero_time_step();
        wait_quiet();
        program_rates(32'hffff_ffff, 32'hffff_ffff, 32'h0, 1'b1);
        send_item(load_item($urandom, $urandom, $urandom, $urandom, 1'b0));
        send_item(step_item(W_MAX, W_MIN, W_MAX, 1'b0));
        send_item(step_item($urandom, $urandom, $urandom, 1'b1));
    endtask

    task automatic test_saturation();
        wait_quiet();
        program_rates(32'h7fff_ffff, 32'h7fff_ffff, 32'hffff_ffff, 1'b0);
        send_item(load_item(W_MAX, W_MAX, W_MAX, W_MIN, 1'b0));
        send_item(step_item(W_MIN, W_MIN, W_MIN, 1'b1));
        send_item(load_item(W_MIN, W_MIN, W_MIN, W_MAX, 1'b0));
        send_item(step_item(W_MAX, W_MAX, W_MAX, 1'b1));
        send_item(step_item(W_MIN, W_MAX, W_MIN, 1'b1));
    endtask

    task automatic test_relaxation();
        wait_quiet();
        program_rates(32'h0000_4000, 32'h0001_0000, 32'h0100_0000, 1'b0);
        send_item(load_item(W_ONE, '0, '0, W_ONE, 1'b0));
        send_item(step_item('0, '0, '0, 1'b0));
        send_item(step_item('0, '0, '0, 1'b0));
        send_item(step_item('0, '0, '0, 1'b1));
        send_item(step_item(32'sh0000_8000, '0, -32'sh0001_0000, 1'b1));
        send_item(step_item('0, 32'sh0000_4000, 32'sh0000_2000, 1'b1));
    endtask

    task automatic test_backpressure();
        wait_quiet();
        program_setting(0);
        sink_hold_cycles = HOLD_STRETCH;
        send_item(load_item(rand_mag(), rand_mag(), rand_mag(), rand_mag(), 1'b1));
        for (int i = 0; i < 10; i++)
            send_item(step_item(rand_rate(), rand_rate(), rand_rate(), 1'b1));
    endtask

    task automatic test_random();
        for (int phase = 0; phase < 5; phase++) begin
            wait_quiet();
            program_setting(phase);
            idling_on = $urandom_range(0, 3) != 0;
            run_sequences(250);
        end
    endtask

    task automatic test_no_idle();
        wait_quiet();
        idling_on = 1'b0;
        program_setting(0);
        run_sequences(150);
    endtask

    initial begin
        t_item blank;
        blank = load_item('0, '0, '0, '0, 1'b0);
        blank.rf_x          = '0;
        blank.rf_y          = '0;
        blank.off_resonance = '0;
        i_rst_n     <= 1'b0;
        i_cfg_we    <= 1'b0;
        i_cfg_idx   <= CFG_LONG_RELAX;
        i_cfg_data  <= '0;
        in_ch.valid <= 1'b0;
        drive_fields(blank);
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_reset_values();
        test_load_emit();
        test_zero_time_step();
        test_saturation();
        test_relaxation();
        test_backpressure();
        test_random();
        test_no_idle();
        wait_quiet();

        if (n_errors == 0 && expected_vectors.size() == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule
